>>> sv/aird_pkg.sv
// Package for the alignment indel run detector: widths, run kind codes,
// the signature and queue push structs and the saturating add. No dependencies.
package aird_pkg;

    localparam int POSITION_BITS = 31;
    localparam int MIN_LEN_BITS  = 16;

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [MIN_LEN_BITS-1:0]  t_min_len;

    localparam t_pos     POS_ONE       = t_pos'(1);
    localparam t_min_len MIN_LEN_RESET = t_min_len'(40);

    // Run kind codes.
    localparam logic [1:0] RUN_NONE = 2'd0;
    localparam logic [1:0] RUN_DEL  = 2'd1;
    localparam logic [1:0] RUN_INS  = 2'd2;

    // Variant kind codes of a signature.
    localparam logic KIND_DEL = 1'b0;
    localparam logic KIND_INS = 1'b1;

    typedef struct packed {
        logic variant_kind;
        t_pos query_from;
        t_pos query_to;
        t_pos subject_from;
        t_pos subject_to;
        logic last_of_run;
    } t_sig;

    // Up to two signatures produced by one accepted item, earlier run first.
    typedef struct packed {
        logic [1:0] num;
        t_sig       first;
        t_sig       second;
    } t_push;

    function automatic t_pos sat_add(input t_pos a, input t_pos b);
        logic [POSITION_BITS:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            sat_add = s[POSITION_BITS] ? '1 : s[POSITION_BITS-1:0];
        end
    endfunction

endpackage

>>> sv/alignment_indel_run_detector_top.sv
// Top level of the alignment indel run detector: joins the column core and
// the result queue. Depends on aird_pkg, aird_core and aird_queue.
//
//   Channel   Direction  Handshake               Payload
//   column    in         i_valid / o_ready       first/last flags, starts, gap flags
//   variant   out        o_valid / i_ready       kind, query and subject spans, last
//   config    in         i_cfg_we (no wait)      i_cfg_data, minimum run length
//
// Each column item is handled in the cycle it is accepted, so one item can be
// accepted every cycle while each item yields at most one signature and i_ready stays high.
// An item that yields two signatures holds o_ready low until its first signature is taken,
// since the two-entry result queue drains one signature per cycle while i_ready is high.
// Reset is synchronous and active low; it empties the queue, clears the
// positions and the open run and sets the minimum length to 40.
// A stall on the output holds the queue; o_ready then drops until there is room.
module alignment_indel_run_detector_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  aird_pkg::t_min_len      i_cfg_data,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_first_column,
    input  aird_pkg::t_pos          i_query_start,
    input  aird_pkg::t_pos          i_subject_start,
    input  logic                    i_query_gap,
    input  logic                    i_subject_gap,
    input  logic                    i_last_column,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_variant_kind,
    output aird_pkg::t_pos          o_query_from,
    output aird_pkg::t_pos          o_query_to,
    output aird_pkg::t_pos          o_subject_from,
    output aird_pkg::t_pos          o_subject_to,
    output logic                    o_last_of_run
);
    import aird_pkg::*;

    t_push push;
    t_sig  head;
    logic  accept;
    logic  pop;
    logic  can_push;

    // An item is accepted when the queue will be empty after this cycle's pop,
    // so both signatures of any item always find room.
    assign o_ready = can_push;
    assign accept  = i_valid && can_push;
    assign pop     = o_valid && i_ready;

    aird_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_first_column  (i_first_column),
        .i_query_start   (i_query_start),
        .i_subject_start (i_subject_start),
        .i_query_gap     (i_query_gap),
        .i_subject_gap   (i_subject_gap),
        .i_last_column   (i_last_column),
        .o_push          (push)
    );

    // Items that close no qualifying run push nothing.
    aird_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (accept && (push.num != 2'd0)),
        .i_data     (push),
        .i_pop      (pop),
        .o_valid    (o_valid),
        .o_can_push (can_push),
        .o_head     (head)
    );

    assign o_variant_kind = head.variant_kind;
    assign o_query_from   = head.query_from;
    assign o_query_to     = head.query_to;
    assign o_subject_from = head.subject_from;
    assign o_subject_to   = head.subject_to;
    assign o_last_of_run  = head.last_of_run;

endmodule

>>> sv/aird_core.sv
// Column tracking core: position and run state, the length register and the
// single pass that turns one column into up to two signatures. Uses aird_pkg.
module aird_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  aird_pkg::t_min_len    i_cfg_data,
    input  logic                  i_accept,
    input  logic                  i_first_column,
    input  aird_pkg::t_pos        i_query_start,
    input  aird_pkg::t_pos        i_subject_start,
    input  logic                  i_query_gap,
    input  logic                  i_subject_gap,
    input  logic                  i_last_column,
    output aird_pkg::t_push       o_push
);
    import aird_pkg::*;

    t_min_len   r_min_len;
    t_pos       r_qpos, r_spos, r_rlen;
    logic [1:0] r_rkind;

    t_pos       q0, s0, l0, q1, s1, l1, q2, s2, l2, q3, s3;
    logic [1:0] k0, k1, k2, kind;
    logic       close1, close2, emit1, emit2, del1, del2;
    t_sig       sig1, sig2;

    always_comb begin
        // A first column drops any open run and reloads the positions.
        q0 = i_first_column ? i_query_start   : r_qpos;
        s0 = i_first_column ? i_subject_start : r_spos;
        k0 = i_first_column ? RUN_NONE        : r_rkind;
        l0 = i_first_column ? '0              : r_rlen;

        // A column with both sides gapped counts as a deletion column.
        if (i_query_gap) begin
            kind = RUN_DEL;
        end else if (i_subject_gap) begin
            kind = RUN_INS;
        end else begin
            kind = RUN_NONE;
        end

        close1 = (k0 != RUN_NONE) && (k0 != kind);
        del1   = (k0 == RUN_DEL);
        emit1  = close1 && (l0 >= t_pos'(r_min_len));
        sig1.variant_kind = del1 ? KIND_DEL : KIND_INS;
        sig1.query_from   = q0;
        sig1.query_to     = sat_add(q0, del1 ? POS_ONE : l0);
        sig1.subject_from = s0;
        sig1.subject_to   = sat_add(s0, del1 ? l0 : POS_ONE);
        sig1.last_of_run  = 1'b0;

        q1 = (close1 && !del1) ? sat_add(q0, l0) : q0;
        s1 = (close1 && del1)  ? sat_add(s0, l0) : s0;
        k1 = close1 ? RUN_NONE : k0;
        l1 = close1 ? '0 : l0;

        q2 = q1;
        s2 = s1;
        k2 = k1;
        l2 = l1;
        if (kind == RUN_NONE) begin
            q2 = sat_add(q1, POS_ONE);
            s2 = sat_add(s1, POS_ONE);
        end else if (k1 == kind) begin
            l2 = sat_add(l1, POS_ONE);
        end else begin
            k2 = kind;
            l2 = POS_ONE;
        end

        close2 = i_last_column && (k2 != RUN_NONE);
        del2   = (k2 == RUN_DEL);
        emit2  = close2 && (l2 >= t_pos'(r_min_len));
        sig2.variant_kind = del2 ? KIND_DEL : KIND_INS;
        sig2.query_from   = q2;
        sig2.query_to     = sat_add(q2, del2 ? POS_ONE : l2);
        sig2.subject_from = s2;
        sig2.subject_to   = sat_add(s2, del2 ? l2 : POS_ONE);
        sig2.last_of_run  = 1'b1;

        q3 = (close2 && !del2) ? sat_add(q2, l2) : q2;
        s3 = (close2 && del2)  ? sat_add(s2, l2) : s2;

        o_push.num    = {1'b0, emit1} + {1'b0, emit2};
        o_push.first  = emit1 ? sig1 : sig2;
        o_push.first.last_of_run = !(emit1 && emit2);
        o_push.second = sig2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RESET;
            r_qpos    <= '0;
            r_spos    <= '0;
            r_rkind   <= RUN_NONE;
            r_rlen    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_len <= i_cfg_data;
            end
            if (i_accept) begin
                r_qpos  <= q3;
                r_spos  <= s3;
                r_rkind <= close2 ? RUN_NONE : k2;
                r_rlen  <= close2 ? '0 : l2;
            end
        end
    end

endmodule

>>> sv/aird_queue.sv
// Two-entry result queue: takes up to two signatures at once when empty and
// hands them out one per item handshake. Uses aird_pkg.
module aird_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  aird_pkg::t_push i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_can_push,
    output aird_pkg::t_sig  o_head
);
    import aird_pkg::*;

    t_sig       r_slot0, r_slot1, n_slot0, n_slot1;
    logic [1:0] r_count, n_count;

    assign o_valid    = (r_count != 2'd0);
    assign o_head     = r_slot0;
    // A push is only taken when the queue is empty after this cycle's pop.
    assign o_can_push = (r_count == 2'd0) || ((r_count == 2'd1) && i_pop);

    always_comb begin
        n_slot0 = i_pop ? r_slot1 : r_slot0;
        n_slot1 = r_slot1;
        n_count = r_count - {1'b0, i_pop};
        if (i_push) begin
            n_slot0 = i_data.first;
            n_slot1 = i_data.second;
            n_count = i_data.num;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule

>>> sv/aird_checker.sv
// Port-level checker for the alignment indel run detector, bound to the top
// level. Depends on aird_pkg and alignment_indel_run_detector_top.
module aird_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           o_ready,
    input logic           o_valid,
    input logic           i_ready,
    input logic           o_variant_kind,
    input aird_pkg::t_pos o_query_from,
    input aird_pkg::t_pos o_query_to,
    input aird_pkg::t_pos o_subject_from,
    input aird_pkg::t_pos o_subject_to,
    input logic           o_last_of_run
);
    import aird_pkg::*;

    // A waiting signature stays offered until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result item dropped while stalled");

    // Reset leaves no result offered.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result offered straight after reset");

    // A deletion spans one query position.
    a_del_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_variant_kind == KIND_DEL) && (o_query_from != '1)
        |-> o_query_to == sat_add(o_query_from, POS_ONE))
        else $error("deletion query span is not one position");

    // An insertion spans one subject position.
    a_ins_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_variant_kind == KIND_INS) && (o_subject_from != '1)
        |-> o_subject_to == sat_add(o_subject_from, POS_ONE))
        else $error("insertion subject span is not one position");

    // While the first of two signatures waits, the queue is full.
    a_pair_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_of_run |-> !o_ready)
        else $error("new item accepted while a signature pair is queued");

endmodule

bind alignment_indel_run_detector_top aird_checker u_aird_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_variant_kind (o_variant_kind),
    .o_query_from   (o_query_from),
    .o_query_to     (o_query_to),
    .o_subject_from (o_subject_from),
    .o_subject_to   (o_subject_to),
    .o_last_of_run  (o_last_of_run)
);
